// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define MCS_ASSERT_COMB(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define MCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_pkg
// Types and constants of the MQTT client session controller.
// ----------------------------------------------------------------------------
package mcs_pkg;

  typedef enum logic [3:0] {
    ST_IDLE           = 4'd0,
    ST_WAITING        = 4'd1,
    ST_CONNECTING     = 4'd2,
    ST_CONNECT_SENT   = 4'd3,
    ST_CONNECTED      = 4'd4,
    ST_PUBLISHING     = 4'd5,
    ST_SUBSCRIBING    = 4'd6,
    ST_SUBSCRIBE_SENT = 4'd7,
    ST_PINGING        = 4'd8,
    ST_DISCONNECTING  = 4'd9
  } session_t;

  typedef enum logic [3:0] {
    EV_CONNECT    = 4'd0,
    EV_TCP_UP     = 4'd1,
    EV_ACK        = 4'd2,
    EV_RECEIVE    = 4'd3,
    EV_CLOSED     = 4'd4,
    EV_POLL       = 4'd5,
    EV_TICK       = 4'd6,
    EV_DISCONNECT = 4'd7,
    EV_PUBLISH    = 4'd8,
    EV_SUBSCRIBE  = 4'd9,
    EV_RETRANSMIT = 4'd10
  } event_t;

  typedef enum logic [2:0] {
    SEND_NONE       = 3'd0,
    SEND_CONNECT    = 3'd1,
    SEND_PUBLISH    = 3'd2,
    SEND_SUBSCRIBE  = 3'd3,
    SEND_PINGREQ    = 3'd4,
    SEND_DISCONNECT = 3'd5
  } send_t;

  localparam logic [3:0] PT_CONNACK  = 4'd2;
  localparam logic [3:0] PT_PUBLISH  = 4'd3;
  localparam logic [3:0] PT_SUBACK   = 4'd9;
  localparam logic [3:0] PT_PINGRESP = 4'd13;

  localparam logic CFG_KEEP_ALIVE = 1'b0;
  localparam logic CFG_DELIVER    = 1'b1;

  localparam logic [15:0] KEEP_ALIVE_RESET = 16'd15;
  localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

  typedef struct packed {
    session_t    session;
    logic        ping_wanted;
    logic        publish_wanted;
    logic        retain_held;
    logic        subscribe_wanted;
    logic [15:0] msg_counter;
    logic [7:0]  last_error;
    logic [15:0] send_elapsed;
    logic [15:0] receive_elapsed;
  } sess_t;

  typedef struct packed {
    logic [3:0]  session_state;
    logic        is_connected;
    send_t       send_kind;
    logic        retain_out;
    logic [15:0] sub_msg_id;
    logic        open_conn;
    logic        close_conn;
    logic        abort_conn;
    logic        deliver;
    logic [6:0]  data_length;
    logic [7:0]  conn_error;
  } result_t;

  function automatic logic in_session(input session_t s);
    return (s == ST_CONNECTED) || (s == ST_PUBLISHING) || (s == ST_SUBSCRIBING) ||
           (s == ST_SUBSCRIBE_SENT) || (s == ST_PINGING);
  endfunction

  // Packet that belongs to a state, if any.
  function automatic send_t send_of(input session_t s);
    send_t k;
    k = SEND_NONE;
    case (s)
      ST_CONNECTING:    k = SEND_CONNECT;
      ST_PUBLISHING:    k = SEND_PUBLISH;
      ST_SUBSCRIBING:   k = SEND_SUBSCRIBE;
      ST_PINGING:       k = SEND_PINGREQ;
      ST_DISCONNECTING: k = SEND_DISCONNECT;
      default:          k = SEND_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/mcs_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_step
// Next session state and result word for one event.
// ----------------------------------------------------------------------------
module mcs_step (
  input  mcs_pkg::sess_t   cur,
  input  logic [15:0]      keep_alive_seconds,
  input  logic             deliver_enabled,
  input  logic [3:0]       mode,
  input  logic [3:0]       packet_type,
  input  logic [7:0]       return_code,
  input  logic             has_data,
  input  logic [6:0]       remaining_length,
  input  logic [7:0]       topic_length,
  input  logic [6:0]       publish_length,
  input  logic             retain,
  output mcs_pkg::sess_t   nxt,
  output mcs_pkg::result_t res
);

  logic           do_tx;
  mcs_pkg::send_t kind;
  logic [15:0]    send_inc;
  logic [15:0]    recv_inc;
  logic [8:0]     need_len;
  logic           len_ok;
  logic [6:0]     diff_len;

  assign send_inc = (cur.send_elapsed != mcs_pkg::COUNT_MAX) ?
                    cur.send_elapsed + 16'd1 : cur.send_elapsed;
  assign recv_inc = (cur.receive_elapsed != mcs_pkg::COUNT_MAX) ?
                    cur.receive_elapsed + 16'd1 : cur.receive_elapsed;
  assign need_len = {1'b0, topic_length} + 9'd2;
  // Clamp at zero: the difference is only taken when it cannot go negative.
  assign len_ok   = ({2'b00, remaining_length} >= need_len);
  assign diff_len = remaining_length - need_len[6:0];

  always_comb begin
    nxt   = cur;
    res   = '0;
    do_tx = 1'b0;
    kind  = mcs_pkg::SEND_NONE;

    unique case (mode)
      mcs_pkg::EV_CONNECT: begin
        if (cur.session == mcs_pkg::ST_IDLE) begin
          nxt.session         = mcs_pkg::ST_WAITING;
          nxt.send_elapsed    = '0;
          nxt.receive_elapsed = '0;
          res.open_conn       = 1'b1;
        end
      end
      mcs_pkg::EV_TCP_UP: begin
        nxt.session = mcs_pkg::ST_CONNECTING;
        do_tx       = 1'b1;
      end
      mcs_pkg::EV_ACK: begin
        unique case (cur.session)
          mcs_pkg::ST_CONNECTING: nxt.session = mcs_pkg::ST_CONNECT_SENT;
          mcs_pkg::ST_PUBLISHING: begin
            nxt.session        = mcs_pkg::ST_CONNECTED;
            nxt.publish_wanted = 1'b0;
          end
          mcs_pkg::ST_PINGING: begin
            nxt.session     = mcs_pkg::ST_CONNECTED;
            nxt.ping_wanted = 1'b0;
          end
          mcs_pkg::ST_SUBSCRIBING: begin
            nxt.session          = mcs_pkg::ST_SUBSCRIBE_SENT;
            nxt.subscribe_wanted = 1'b0;
          end
          mcs_pkg::ST_DISCONNECTING: begin
            nxt.session    = mcs_pkg::ST_IDLE;
            res.close_conn = 1'b1;
          end
          default: ;
        endcase
      end
      mcs_pkg::EV_RECEIVE: begin
        if (has_data) begin
          case (packet_type)
            mcs_pkg::PT_CONNACK: begin
              if (return_code == 8'd0) begin
                nxt.session = mcs_pkg::ST_CONNECTED;
              end else begin
                nxt.session    = mcs_pkg::ST_IDLE;
                nxt.last_error = return_code;
                res.close_conn = 1'b1;
              end
            end
            mcs_pkg::PT_SUBACK:   nxt.session = mcs_pkg::ST_CONNECTED;
            mcs_pkg::PT_PINGRESP: nxt.ping_wanted = 1'b0;
            mcs_pkg::PT_PUBLISH: begin
              if (deliver_enabled) begin
                res.deliver     = 1'b1;
                res.data_length = len_ok ? diff_len : 7'd0;
              end
            end
            default: ;
          endcase
          nxt.receive_elapsed = '0;
        end
      end
      mcs_pkg::EV_CLOSED: begin
        nxt.session    = mcs_pkg::ST_IDLE;
        res.close_conn = 1'b1;
      end
      mcs_pkg::EV_POLL: begin
        if (cur.session == mcs_pkg::ST_CONNECTED) begin
          if (cur.publish_wanted) begin
            nxt.session = mcs_pkg::ST_PUBLISHING;
            do_tx       = 1'b1;
          end else if (cur.subscribe_wanted) begin
            nxt.session     = mcs_pkg::ST_SUBSCRIBING;
            nxt.msg_counter = cur.msg_counter + 16'd1;
            do_tx           = 1'b1;
          end else if (cur.ping_wanted) begin
            nxt.session = mcs_pkg::ST_PINGING;
            do_tx       = 1'b1;
          end
        end
      end
      mcs_pkg::EV_TICK: begin
        if (cur.session != mcs_pkg::ST_IDLE) begin
          nxt.send_elapsed    = send_inc;
          nxt.receive_elapsed = recv_inc;
          if (send_inc >= keep_alive_seconds || recv_inc >= keep_alive_seconds) begin
            if (mcs_pkg::in_session(cur.session)) begin
              if (!cur.ping_wanted) begin
                nxt.ping_wanted     = 1'b1;
                nxt.send_elapsed    = '0;
                nxt.receive_elapsed = '0;
              end else begin
                nxt.session = mcs_pkg::ST_DISCONNECTING;
                do_tx       = 1'b1;
              end
            end else begin
              nxt.session    = mcs_pkg::ST_IDLE;
              res.abort_conn = 1'b1;
            end
          end
        end
      end
      mcs_pkg::EV_DISCONNECT: begin
        if (mcs_pkg::in_session(cur.session)) begin
          nxt.session = mcs_pkg::ST_DISCONNECTING;
          do_tx       = 1'b1;
        end
      end
      mcs_pkg::EV_PUBLISH: begin
        nxt.retain_held    = retain;
        nxt.publish_wanted = (publish_length != 7'd0);
      end
      mcs_pkg::EV_SUBSCRIBE:  nxt.subscribe_wanted = 1'b1;
      mcs_pkg::EV_RETRANSMIT: do_tx = 1'b1;
      default: ;
    endcase

    // Send the packet of the state reached, restart the send timer.
    if (do_tx) begin
      kind = mcs_pkg::send_of(nxt.session);
    end
    if (kind != mcs_pkg::SEND_NONE) begin
      res.send_kind    = kind;
      nxt.send_elapsed = '0;
    end
    if (kind == mcs_pkg::SEND_PUBLISH) begin
      res.retain_out = nxt.retain_held;
    end
    if (kind == mcs_pkg::SEND_SUBSCRIBE) begin
      res.sub_msg_id = nxt.msg_counter;
    end

    res.session_state = nxt.session;
    res.is_connected  = mcs_pkg::in_session(nxt.session);
    res.conn_error    = nxt.last_error;
  end

endmodule

// ===== rtl/mqtt_client_session_fsm.sv =====
`timescale 1ns / 1ps
// Each result word is registered: in the output register, or first in the skid register while the output stalls.
// Throughput: one event per cycle while in_stall is low; the session update is a single pass of logic.
// A result held by out_stall goes to a skid register; in_stall rises only while it is full.
// Reset (rst, synchronous): session idle, all flags and counters zero, keep-alive 15,
// delivery off, no result pending.
// ----------------------------------------------------------------------------
// mqtt_client_session_fsm
// MQTT client session controller: one event word in, one result word out.
// ----------------------------------------------------------------------------
module mqtt_client_session_fsm (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // event channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  mode,
  input  logic [3:0]  packet_type,
  input  logic [7:0]  return_code,
  input  logic        has_data,
  input  logic [6:0]  remaining_length,
  input  logic [7:0]  topic_length,
  input  logic [6:0]  publish_length,
  input  logic        retain,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  session_state,
  output logic        is_connected,
  output logic [2:0]  send_kind,
  output logic        retain_out,
  output logic [15:0] sub_msg_id,
  output logic        open_conn,
  output logic        close_conn,
  output logic        abort_conn,
  output logic        deliver,
  output logic [6:0]  data_length,
  output logic [7:0]  conn_error
);

  // Configuration registers.
  logic [15:0] keep_alive_seconds;
  logic        deliver_enabled;

  // Session state and its next value.
  mcs_pkg::sess_t   sess;
  mcs_pkg::sess_t   sess_next;
  mcs_pkg::result_t res_next;

  // Output register and skid stage.
  mcs_pkg::result_t out_q;
  mcs_pkg::result_t skid_q;
  logic             skid_valid;

  logic accept;
  logic out_free;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_alive_seconds <= mcs_pkg::KEEP_ALIVE_RESET;
      deliver_enabled    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcs_pkg::CFG_KEEP_ALIVE: keep_alive_seconds <= cfg_data;
        mcs_pkg::CFG_DELIVER:    deliver_enabled    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mcs_step u_step (
    .cur                (sess),
    .keep_alive_seconds (keep_alive_seconds),
    .deliver_enabled    (deliver_enabled),
    .mode               (mode),
    .packet_type        (packet_type),
    .return_code        (return_code),
    .has_data           (has_data),
    .remaining_length   (remaining_length),
    .topic_length       (topic_length),
    .publish_length     (publish_length),
    .retain             (retain),
    .nxt                (sess_next),
    .res                (res_next)
  );

  // Advance the session on every accepted event; all zero is the idle session.
  always_ff @(posedge clk) begin
    if (rst) begin
      sess <= '0;
    end else if (accept) begin
      sess <= sess_next;
    end
  end

  // Result path: load the output register when it frees up, else park the
  // new word in the skid stage. The skid stage drains before new events enter.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res_next;
      end
    end else if (accept) begin
      skid_q <= res_next;
    end
  end

  assign session_state = out_q.session_state;
  assign is_connected  = out_q.is_connected;
  assign send_kind     = out_q.send_kind;
  assign retain_out    = out_q.retain_out;
  assign sub_msg_id    = out_q.sub_msg_id;
  assign open_conn     = out_q.open_conn;
  assign close_conn    = out_q.close_conn;
  assign abort_conn    = out_q.abort_conn;
  assign deliver       = out_q.deliver;
  assign data_length   = out_q.data_length;
  assign conn_error    = out_q.conn_error;

endmodule

// ===== rtl/mcs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_checker
// Port-level checks of the session controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  session_state,
  input logic        is_connected,
  input logic [2:0]  send_kind,
  input logic        retain_out,
  input logic [15:0] sub_msg_id,
  input logic        open_conn,
  input logic        deliver,
  input logic [6:0]  data_length
);

  logic state_live;
  logic none_sent;
  logic pkt_clear;
  logic in_wait;

  assign state_live = (session_state >= mcs_pkg::ST_CONNECTED) &&
                      (session_state <= mcs_pkg::ST_PINGING);
  assign none_sent  = out_valid && (send_kind == mcs_pkg::SEND_NONE);
  assign pkt_clear  = (retain_out == 1'b0) && (sub_msg_id == 16'd0);
  assign in_wait    = (session_state == mcs_pkg::ST_WAITING);

  `MCS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result word dropped")
  `MCS_ASSERT_COMB(a_connected, clk, rst, out_valid, is_connected == state_live, "bad is_connected")
  `MCS_ASSERT_COMB(a_send_fields, clk, rst, none_sent, pkt_clear, "packet fields with no send")
  `MCS_ASSERT_COMB(a_deliver_len, clk, rst, out_valid && !deliver, data_length == 7'd0, "stray length")
  `MCS_ASSERT_COMB(a_open_wait, clk, rst, out_valid && open_conn, in_wait, "open outside waiting")

endmodule

bind mqtt_client_session_fsm mcs_checker u_mcs_checker (.*);
